[rtl/vct_pkg.sv]
// ----------------------------------------------------------------------------
// Velocity calibration table package
// Field widths, opcodes and the fixed arithmetic constants of the table.
// ----------------------------------------------------------------------------
package vct_pkg;

   localparam int OP_W    = 2;
   localparam int TRAIN_W = 7;
   localparam int LEVEL_W = 4;
   localparam int VAL_W   = 12;
   localparam int VEL_W   = 13;
   localparam int STOP_W  = 14;

   localparam int LINEAR_LEVEL = 5;
   localparam int FB_SLOPE     = 63;
   localparam int FB_OFFSET    = 281;

   // floor(p / 5) == (p * 26215) >> 17 for every p below 2**14
   localparam int LIN_PROD_W   = 14;
   localparam int DIV5_RECIP   = 26215;
   localparam int DIV5_RECIP_W = 15;
   localparam int DIV5_SHIFT   = 17;
   localparam int LIN_MUL_W    = LIN_PROD_W + DIV5_RECIP_W;

   typedef enum logic [OP_W-1:0] {
      OP_RECORD = 2'd0,
      OP_QUERY  = 2'd1,
      OP_SET    = 2'd2
   } op_type;

endpackage

[rtl/velocity_calibration_table.sv]
// ----------------------------------------------------------------------------
// Velocity calibration table
// Per train and speed level velocity estimate kept as a moving average of
// recent samples, with linear and fallback velocities and stopping distance.
// ----------------------------------------------------------------------------
// After reset the block sweeps its estimate memory one row a cycle over all
// 16*NUM_TRAINS rows with busy high. An item is taken when start is high
// and busy is low; exactly one result follows, flagged by rsp_valid for one
// cycle with no way for the receiver to hold it off, and busy drops in that
// same cycle so the next item can start. A record walks the pair's sample
// ring through the single read port of the ring memory, then divides by the
// sample count one quotient bit per cycle. A zero sample is not stored but
// still refreshes the average. Items with train or level out of range
// return zero velocity and distance without touching the table.
// ----------------------------------------------------------------------------
module velocity_calibration_table #(
   parameter int NUM_TRAINS   = 80,
   parameter int SPEED_LEVELS = 15,
   parameter int SAMPLE_COUNT = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [vct_pkg::OP_W-1:0]            req_opcode,
   input  logic [vct_pkg::TRAIN_W-1:0]         req_train_id,
   input  logic [vct_pkg::LEVEL_W-1:0]         req_speed_level,
   input  logic [vct_pkg::VAL_W-1:0]           req_value,
   output logic                                rsp_valid,
   output logic signed [vct_pkg::VEL_W-1:0]    rsp_velocity_out,
   output logic signed [vct_pkg::STOP_W-1:0]   rsp_stop_distance
);
   import vct_pkg::*;

   localparam int ROW_W      = (NUM_TRAINS > 1) ? $clog2(NUM_TRAINS) : 1;
   localparam int META_AW    = ROW_W + LEVEL_W;
   localparam int META_DEPTH = NUM_TRAINS * (2 ** LEVEL_W);
   localparam int POS_W      = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam int FILL_W     = $clog2(SAMPLE_COUNT + 1);
   localparam int RING_AW    = META_AW + POS_W;
   localparam int RING_DEPTH = META_DEPTH * (2 ** POS_W);
   localparam int TOTAL_W    = VAL_W + FILL_W;

   typedef struct packed {
      logic              valid;
      logic [VAL_W-1:0]  est;
      logic [FILL_W-1:0] fill;
      logic [POS_W-1:0]  pos;
   } meta_type;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b0000000001,
      ST_IDLE  = 10'b0000000010,
      ST_META  = 10'b0000000100,
      ST_SUM   = 10'b0000001000,
      ST_DIV   = 10'b0000010000,
      ST_WRITE = 10'b0000100000,
      ST_EFF   = 10'b0001000000,
      ST_L5    = 10'b0010000000,
      ST_VEL   = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic [VAL_W-1:0]         value_ff, value_in;
   logic                     oor_ff, oor_in;
   meta_type                 meta_ff, meta_in;
   logic [FILL_W-1:0]        idx_ff, idx_in;
   logic                     pend_ff, pend_in;
   logic [TOTAL_W-1:0]       acc_ff, acc_in;
   logic [LIN_PROD_W-1:0]    prod_ff, prod_in;
   logic                     l5_valid_ff, l5_valid_in;
   logic signed [VEL_W-1:0]  v_ff, v_in;
   logic [META_AW-1:0]       clr_ff, clr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VEL_W-1:0]  rsp_vel_ff, rsp_vel_in;
   logic signed [STOP_W-1:0] rsp_stop_ff, rsp_stop_in;

   meta_type                 meta_mem [META_DEPTH];
   meta_type                 meta_rdata_ff;
   logic                     meta_we;
   logic [META_AW-1:0]       meta_waddr;
   meta_type                 meta_wdata;
   logic [META_AW-1:0]       meta_raddr;

   logic [VAL_W-1:0]         ring_mem [RING_DEPTH];
   logic [VAL_W-1:0]         ring_rdata_ff;
   logic                     ring_we;
   logic [RING_AW-1:0]       ring_waddr;
   logic [VAL_W-1:0]         ring_wdata;
   logic [RING_AW-1:0]       ring_raddr;

   logic                     div_start;
   logic                     div_done;
   logic [VAL_W-1:0]         div_quot;

   logic [META_AW-1:0]       pair;
   logic                     in_range;
   logic                     issue;
   logic [POS_W-1:0]         pos_next;
   logic [FILL_W-1:0]        fill_next;
   logic signed [VEL_W-1:0]  fb_vel;
   logic [LIN_MUL_W-1:0]     lin_mul;
   logic [VAL_W-1:0]         lin_q;
   logic signed [VEL_W+1:0]  v_ext;
   logic signed [VEL_W+1:0]  v3;
   logic signed [VEL_W+1:0]  v3_round;
   logic signed [STOP_W-1:0] stop;

   assign pair     = {row_ff, level_ff};
   assign in_range = (9'(req_train_id) < 9'(NUM_TRAINS))
                     && (5'(req_speed_level) < 5'(SPEED_LEVELS));
   assign issue    = idx_ff < meta_ff.fill;
   assign pos_next = (meta_rdata_ff.pos == POS_W'(SAMPLE_COUNT - 1))
                     ? '0 : meta_rdata_ff.pos + 1'b1;
   assign fill_next = (meta_rdata_ff.fill == FILL_W'(SAMPLE_COUNT))
                     ? meta_rdata_ff.fill : meta_rdata_ff.fill + 1'b1;

   assign fb_vel   = signed'(VEL_W'(VEL_W'(level_ff) * VEL_W'(FB_SLOPE))
                             - VEL_W'(FB_OFFSET));
   assign lin_mul  = LIN_MUL_W'(prod_ff) * LIN_MUL_W'(DIV5_RECIP);
   assign lin_q    = lin_mul[DIV5_SHIFT +: VAL_W];

   assign v_ext    = {{2{v_ff[VEL_W-1]}}, v_ff};
   assign v3       = v_ext + (v_ext <<< 1);
   assign v3_round = v3 + {{(VEL_W+1){1'b0}}, v3[VEL_W+1]};
   assign stop     = v3_round[VEL_W+1:1];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      level_in     = level_ff;
      value_in     = value_ff;
      oor_in       = oor_ff;
      meta_in      = meta_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      l5_valid_in  = l5_valid_ff;
      v_in         = v_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_vel_in   = rsp_vel_ff;
      rsp_stop_in  = rsp_stop_ff;
      meta_we      = 1'b0;
      meta_waddr   = pair;
      meta_wdata   = meta_ff;
      meta_raddr   = pair;
      ring_we      = 1'b0;
      ring_waddr   = {pair, meta_rdata_ff.pos};
      ring_wdata   = value_ff;
      ring_raddr   = {pair, idx_ff[POS_W-1:0]};
      div_start    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == META_AW'(META_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            meta_raddr = {ROW_W'(req_train_id), req_speed_level};
            if (start) begin
               op_in       = op_type'(req_opcode);
               row_in      = ROW_W'(req_train_id);
               level_in    = req_speed_level;
               value_in    = req_value;
               l5_valid_in = 1'b0;
               oor_in      = !in_range;
               state_in    = in_range ? ST_META : ST_VEL;
            end
         end
         ST_META: begin
            meta_in = meta_rdata_ff;
            idx_in  = '0;
            acc_in  = '0;
            pend_in = 1'b0;
            case (op_ff)
               OP_RECORD: begin
                  if (value_ff != '0) begin
                     ring_we      = 1'b1;
                     meta_in.pos  = pos_next;
                     meta_in.fill = fill_next;
                  end
                  state_in = ST_SUM;
               end
               OP_SET: begin
                  meta_in.est   = value_ff;
                  meta_in.valid = 1'b1;
                  state_in      = ST_WRITE;
               end
               default: begin
                  state_in = ST_EFF;
               end
            endcase
         end
         ST_SUM: begin
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            pend_in = issue;
            if (pend_ff) begin
               acc_in = acc_ff + TOTAL_W'(ring_rdata_ff);
            end
            if (!issue && !pend_ff) begin
               if (meta_ff.fill == '0) begin
                  state_in = ST_EFF;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               meta_in.est   = div_quot;
               meta_in.valid = 1'b1;
               state_in      = ST_WRITE;
            end
         end
         ST_WRITE: begin
            meta_we  = 1'b1;
            state_in = ST_EFF;
         end
         ST_EFF: begin
            meta_raddr = {row_ff, LEVEL_W'(LINEAR_LEVEL)};
            state_in   = (level_ff < LEVEL_W'(LINEAR_LEVEL)) ? ST_L5 : ST_VEL;
         end
         ST_L5: begin
            prod_in     = LIN_PROD_W'(level_ff) * LIN_PROD_W'(meta_rdata_ff.est);
            l5_valid_in = meta_rdata_ff.valid;
            state_in    = ST_VEL;
         end
         ST_VEL: begin
            if (oor_ff) begin
               v_in = '0;
            end else if (l5_valid_ff) begin
               v_in = signed'({1'b0, lin_q});
            end else if (!meta_ff.valid) begin
               v_in = fb_vel;
            end else begin
               v_in = signed'({1'b0, meta_ff.est});
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_vel_in   = v_ff;
            rsp_stop_in  = stop;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      row_ff      <= row_in;
      level_ff    <= level_in;
      value_ff    <= value_in;
      oor_ff      <= oor_in;
      meta_ff     <= meta_in;
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      l5_valid_ff <= l5_valid_in;
      v_ff        <= v_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_stop_ff <= rsp_stop_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rdata_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rdata_ff <= ring_mem[ring_raddr];
   end

   vct_avg_div #(
      .FILL_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .total    (acc_ff),
      .count    (meta_ff.fill),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_velocity_out  = rsp_vel_ff;
   assign rsp_stop_distance = rsp_stop_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (idx_ff <= meta_ff.fill))
      else $error("ring walk ran past the fill count");

   a_ring_nonzero: assert property (@(posedge clock) disable iff (reset)
      ring_we |-> (ring_wdata != '0))
      else $error("zero sample written into ring");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(oor_ff)) |->
         (rsp_velocity_out == '0 && rsp_stop_distance == '0))
      else $error("out of range beat returned nonzero result");

endmodule

[rtl/vct_avg_div.sv]
// ----------------------------------------------------------------------------
// Sample average divider
// Restoring divider, one quotient bit per cycle; the quotient is known to
// fit the sample width, so only that many steps are taken.
// ----------------------------------------------------------------------------
module vct_avg_div #(
   parameter int FILL_W = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [vct_pkg::VAL_W+FILL_W-1:0]      total,
   input  logic [FILL_W-1:0]                     count,
   output logic                                  done,
   output logic [vct_pkg::VAL_W-1:0]             quotient
);
   import vct_pkg::*;

   localparam int TOTAL_W = VAL_W + FILL_W;
   localparam int STEP_W  = $clog2(VAL_W + 1);

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [FILL_W-1:0]   rem_ff, rem_in;
   logic [FILL_W-1:0]   count_ff, count_in;
   logic [VAL_W-1:0]    sh_ff, sh_in;
   logic [FILL_W:0]     trial;
   logic [FILL_W:0]     diff;
   logic                ge;

   assign trial = {rem_ff, sh_ff[VAL_W-1]};
   assign diff  = trial - {1'b0, count_ff};
   assign ge    = trial >= {1'b0, count_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      sh_in     = sh_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         rem_in    = total[TOTAL_W-1:VAL_W];
         sh_in     = total[VAL_W-1:0];
         count_in  = count;
      end else if (active_ff) begin
         rem_in = ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
         sh_in  = {sh_ff[VAL_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(VAL_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rem_ff   <= rem_in;
      count_ff <= count_in;
      sh_ff    <= sh_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

   a_rem_below_count: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (rem_ff < count_ff))
      else $error("divider remainder not below divisor");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !active_ff)
      else $error("divider restarted while running");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !active_ff)
      else $error("divider done while still running");

endmodule

[tb/sv/velocity_calibration_table_tb.sv]
// ----------------------------------------------------------------------------
// Velocity calibration table testbench
// Sends record, query and set commands over the start/busy handshake and
// predicts each reading (effective velocity and stopping distance) from a
// local copy of the per-pair sample rings and estimates. Every rsp_valid
// beat is checked in order against the oldest pending reading. Directed
// tests cover the fallback line, range limits, the unused opcode, empty and
// zero-sample records, linear scaling from level 5 and ring wrap-around.
// Random traffic then concentrates on a few trains so rings fill and wrap.
// ----------------------------------------------------------------------------
module velocity_calibration_table_tb;
   import vct_pkg::*;

   localparam int NUM_TRAINS   = 80;
   localparam int SPEED_LEVELS = 15;
   localparam int SAMPLE_COUNT = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 40;
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   typedef struct {
      logic signed [VEL_W-1:0]  velocity;
      logic signed [STOP_W-1:0] distance;
   } reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [OP_W-1:0]           req_opcode = '0;
   logic [TRAIN_W-1:0]        req_train_id = '0;
   logic [LEVEL_W-1:0]        req_speed_level = '0;
   logic [VAL_W-1:0]          req_value = '0;
   logic                      rsp_valid;
   logic signed [VEL_W-1:0]   rsp_velocity_out;
   logic signed [STOP_W-1:0]  rsp_stop_distance;

   logic [VAL_W-1:0] est_mem   [NUM_TRAINS][SPEED_LEVELS];
   bit               est_valid [NUM_TRAINS][SPEED_LEVELS];
   logic [VAL_W-1:0] ring_mem  [NUM_TRAINS][SPEED_LEVELS][SAMPLE_COUNT];
   int               ring_pos  [NUM_TRAINS][SPEED_LEVELS];

   reading_type pending_readings[$];
   int  failures = 0;
   int  readings_checked = 0;
   int  cycle_count = 0;
   int  n_record = 0, n_query = 0, n_set = 0, n_unused = 0, n_out_of_range = 0;
   bit  idle_enabled = 1'b1;

   velocity_calibration_table #(
      .NUM_TRAINS(NUM_TRAINS),
      .SPEED_LEVELS(SPEED_LEVELS),
      .SAMPLE_COUNT(SAMPLE_COUNT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_train_id(req_train_id),
      .req_speed_level(req_speed_level),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_velocity_out(rsp_velocity_out),
      .rsp_stop_distance(rsp_stop_distance)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int effective_velocity_of(int t, int s);
      if (s < LINEAR_LEVEL && est_valid[t][LINEAR_LEVEL])
         return (s * int'(est_mem[t][LINEAR_LEVEL])) / LINEAR_LEVEL;
      if (!est_valid[t][s])
         return s * FB_SLOPE - FB_OFFSET;
      return int'(est_mem[t][s]);
   endfunction

   // update the local table and queue the reading this command yields
   task automatic predict_reading(input logic [OP_W-1:0] opcode, input int t, input int s,
                                  input int value);
      reading_type r;
      int total;
      int count;
      int v;
      int d;
      if (t >= NUM_TRAINS || s >= SPEED_LEVELS) begin
         n_out_of_range++;
         r.velocity = '0;
         r.distance = '0;
         pending_readings.push_back(r);
         return;
      end
      if (opcode == OP_RECORD) begin
         n_record++;
         if (value != 0) begin
            ring_mem[t][s][ring_pos[t][s]] = value[VAL_W-1:0];
            ring_pos[t][s] = (ring_pos[t][s] + 1) % SAMPLE_COUNT;
         end
         total = 0;
         count = 0;
         for (int i = 0; i < SAMPLE_COUNT; i++) begin
            if (ring_mem[t][s][i] != 0) begin
               total += int'(ring_mem[t][s][i]);
               count++;
            end
         end
         if (count > 0) begin
            est_mem[t][s] = VAL_W'(total / count);
            est_valid[t][s] = 1'b1;
         end
      end else if (opcode == OP_SET) begin
         n_set++;
         est_mem[t][s] = value[VAL_W-1:0];
         est_valid[t][s] = 1'b1;
      end else if (opcode == OP_QUERY) begin
         n_query++;
      end else begin
         n_unused++;
      end
      v = effective_velocity_of(t, s);
      d = (15 * v) / 10;
      r.velocity = v[VEL_W-1:0];
      r.distance = d[STOP_W-1:0];
      pending_readings.push_back(r);
   endtask

   function automatic int pick_gap();
      int r;
      if (!idle_enabled)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_beat(input logic [OP_W-1:0] opcode, input int train, input int level,
                            input int value);
      int gap;
      start           <= 1'b1;
      req_opcode      <= opcode;
      req_train_id    <= train[TRAIN_W-1:0];
      req_speed_level <= level[LEVEL_W-1:0];
      req_value       <= value[VAL_W-1:0];
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predict_reading(opcode, train, level, value);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every queued reading has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_readings.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_valid) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected reading: velocity_out %0d stop_distance %0d",
                   rsp_velocity_out, rsp_stop_distance);
            failures++;
         end else begin
            e = pending_readings.pop_front();
            readings_checked++;
            if (rsp_velocity_out !== e.velocity) begin
               $error("velocity_out: expected %0d, actual %0d", e.velocity, rsp_velocity_out);
               failures++;
            end
            if (rsp_stop_distance !== e.distance) begin
               $error("stop_distance: expected %0d, actual %0d", e.distance,
                      rsp_stop_distance);
               failures++;
            end
         end
      end
   end

   task automatic test_fallback_and_range();
      send_beat(OP_QUERY, 0, 0, 0);
      send_beat(OP_QUERY, NUM_TRAINS - 1, SPEED_LEVELS - 1, 0);
      send_beat(OP_QUERY, 127, 3, 0);
      send_beat(OP_QUERY, NUM_TRAINS, 0, 0);
      send_beat(OP_SET, 1, 15, 4095);
      send_beat(OP_RESERVED, 2, 7, 4095);
   endtask

   task automatic test_record_and_set();
      send_beat(OP_RECORD, 2, 7, 0);
      send_beat(OP_RECORD, 2, 7, 4095);
      send_beat(OP_RECORD, 2, 7, 1);
      send_beat(OP_SET, 2, 7, 100);
      send_beat(OP_RECORD, 2, 7, 0);
      send_beat(OP_SET, 3, 9, 0);
   endtask

   task automatic test_linear_scaling();
      send_beat(OP_SET, 3, LINEAR_LEVEL, 4095);
      send_beat(OP_QUERY, 3, 4, 0);
      send_beat(OP_QUERY, 3, 0, 0);
      send_beat(OP_SET, 3, LINEAR_LEVEL, 0);
      send_beat(OP_QUERY, 3, 2, 0);
   endtask

   task automatic test_ring_wrap();
      for (int i = 0; i <= SAMPLE_COUNT; i++)
         send_beat(OP_RECORD, 4, LINEAR_LEVEL, $urandom_range(1, 4095));
      send_beat(OP_QUERY, 4, 3, 0);
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [OP_W-1:0] opcode;
      int train;
      int level;
      int value;
      int r;
      for (int i = 0; i < n_items; i++) begin
         idle_enabled = ((i % 200) >= 40);
         r = $urandom_range(0, 99);
         if (r < 6) begin
            if ($urandom_range(0, 1) == 0) begin
               train = $urandom_range(NUM_TRAINS, 127);
               level = $urandom_range(0, 15);
            end else begin
               train = $urandom_range(0, NUM_TRAINS - 1);
               level = $urandom_range(SPEED_LEVELS, 15);
            end
         end else begin
            if ($urandom_range(0, 3) == 0)
               train = $urandom_range(0, NUM_TRAINS - 1);
            else
               train = $urandom_range(60, 67);
            if ($urandom_range(0, 2) == 0)
               level = LINEAR_LEVEL;
            else
               level = $urandom_range(0, SPEED_LEVELS - 1);
         end
         r = $urandom_range(0, 99);
         if (r < 50)
            opcode = OP_RECORD;
         else if (r < 75)
            opcode = OP_QUERY;
         else if (r < 93)
            opcode = OP_SET;
         else
            opcode = OP_RESERVED;
         r = $urandom_range(0, 99);
         if (r < 10)
            value = 0;
         else if (r < 15)
            value = 4095;
         else
            value = $urandom_range(1, 4095);
         send_beat(opcode, train, level, value);
      end
      idle_enabled = 1'b1;
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 6; i++)
         send_beat(OP_RECORD, 65, $urandom_range(0, SPEED_LEVELS - 1), $urandom_range(1, 4095));
      wait_for_drain();
      send_beat(OP_QUERY, 65, LINEAR_LEVEL, 0);
   endtask

   initial begin
      for (int t = 0; t < NUM_TRAINS; t++) begin
         for (int s = 0; s < SPEED_LEVELS; s++) begin
            est_mem[t][s] = '0;
            est_valid[t][s] = 1'b0;
            ring_pos[t][s] = 0;
            for (int i = 0; i < SAMPLE_COUNT; i++)
               ring_mem[t][s][i] = '0;
         end
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_fallback_and_range();
      test_record_and_set();
      test_linear_scaling();
      test_ring_wrap();
      test_random_traffic(500);
      test_drain_pause();
      test_random_traffic(500);

      wait_for_drain();
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d record, %0d query, %0d set, %0d unused-opcode beats",
               n_record, n_query, n_set, n_unused);
      $display("plus %0d out-of-range beats; %0d readings checked, %0d failures",
               n_out_of_range, readings_checked, failures);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
